>>> design/afu_pkg.sv
// Shared types, codes and constants for the activation function unit.
// Holds the sigmoid table, built at elaboration. No dependencies.
package afu_pkg;

    localparam int NUM_STAGES = 4;
    localparam int ROM_LAST   = 256;

    localparam logic [63:0] ROM_STEP_C  = 64'd4034748382;
    localparam logic [12:0] ALPHA_RESET = 13'd41;

    // Register select, taken from the word address bit of paddr
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    typedef enum logic [2:0] {
        MODE_SIGMOID   = 3'd0,
        MODE_SIGMOID_D = 3'd1,
        MODE_TANH      = 3'd2,
        MODE_TANH_D    = 3'd3,
        MODE_RELU      = 3'd4,
        MODE_RELU_D    = 3'd5,
        MODE_LEAKY     = 3'd6,
        MODE_LEAKY_D   = 3'd7
    } t_mode;

    typedef logic [16:0] t_sig_rom [ROM_LAST+1];

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

    // sigmoid(k/16) in unsigned Q0.16; e tracks exp(-k/16) in Q0.32
    function automatic t_sig_rom f_build_sig_rom();
        t_sig_rom    rom;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        e = 64'd1 << 32;
        for (int k = 0; k <= ROM_LAST; k++) begin
            d   = (64'd1 << 32) + e;
            num = (64'd1 << 48) + (d >> 1);
            rem = '0;
            q   = '0;
            // restoring long division, one quotient bit a step
            for (int n = 48; n >= 0; n--) begin
                rem = {rem[62:0], num[n]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[n] = 1'b1;
                end
            end
            rom[k] = q[16:0];
            e = (e * ROM_STEP_C + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = f_build_sig_rom();

endpackage

>>> design/activation_function_unit.sv
// Activation function unit: sigmoid, tanh, ReLU, leaky ReLU and derivatives.
// An accepted input beat reaches its output beat through the table read,
// interpolation, derivative multiplier and rounding stage, one register each.
// Throughput one beat per cycle; a stalled output backs up stage by stage.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets mode to sigmoid
// and alpha to 41. The sigmoid table is constant and needs no clearing pass.
module activation_function_unit import afu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_x_value,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output logic signed [15:0] o_y_value,
    input  logic               i_out_stall
);

    t_mode       w_mode;
    logic [12:0] w_alpha;
    t_pipe_ctl   w_ctl;

    afu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode),
        .o_alpha (w_alpha)
    );

    afu_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_ctl       (w_ctl)
    );

    afu_datapath u_datapath (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_mode    (w_mode),
        .i_alpha   (w_alpha),
        .i_x_value (i_x_value),
        .o_y_value (o_y_value)
    );

    assign o_out_valid = w_ctl.valid[NUM_STAGES-1];

`ifndef ASSERT_OFF
    // an open output lets every stage move, so the input never stalls
    a_no_stall_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall
    ) else $error("input stalled while output was open");

    // input stall only with a full pipeline behind a stalled output
    a_stall_means_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_ctl.valid == '1) && i_out_stall
    ) else $error("input stalled with a bubble in the pipeline");

    a_reset_empties: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out_valid
    ) else $error("output beat right after reset");
`endif

endmodule

>>> design/afu_regs.sv
// Configuration registers (mode, alpha) behind an APB-style port.
// Depends on afu_pkg for the register select codes and mode type.
module afu_regs import afu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_mode       o_mode,
    output logic [12:0] o_alpha
);

    t_mode       r_mode;
    logic [12:0] r_alpha;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SIGMOID;
            r_alpha <= ALPHA_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MODE:  r_mode  <= t_mode'(pwdata[2:0]);
                REG_ALPHA: r_alpha <= pwdata[12:0];
                default:   r_alpha <= r_alpha;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE:  prdata = 32'(r_mode);
            REG_ALPHA: prdata = 32'(r_alpha);
            default:   prdata = '0;
        endcase
    end

    assign o_mode  = r_mode;
    assign o_alpha = r_alpha;

endmodule

>>> design/afu_pipe_ctrl.sv
// Valid bits and stall propagation for the datapath stages.
// Depends on afu_pkg for the stage count and control struct.
module afu_pipe_ctrl import afu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output logic      o_in_stall,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] prev_valid;
    logic [NUM_STAGES:0]   ready;

    // a stage may load when it is empty or the one after it moves
    always_comb begin
        ready[NUM_STAGES] = !i_out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            ready[k] = !r_valid[k] || ready[k+1];
        end
    end

    assign prev_valid = {r_valid[NUM_STAGES-2:0], i_in_valid};
    assign n_valid    = (ready[NUM_STAGES-1:0] & prev_valid)
                      | (~ready[NUM_STAGES-1:0] & r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = !ready[0];
    assign o_ctl.load  = ready[NUM_STAGES-1:0];
    assign o_ctl.valid = r_valid;

endmodule

>>> design/afu_datapath.sv
// Four-stage activation datapath: table read, interpolation, multiply, round.
// Depends on afu_pkg for the sigmoid table, mode codes and control struct.
module afu_datapath import afu_pkg::*; (
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  t_mode              i_mode,
    input  logic [12:0]        i_alpha,
    input  logic signed [15:0] i_x_value,
    output logic signed [15:0] o_y_value
);

    // ---------------- stage A: magnitude and table read ----------------
    logic [15:0] x_u;
    logic [15:0] mag;
    logic [16:0] b_arg;
    logic [8:0]  idx;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [10:0] diff;

    logic [15:0] r_a_x;
    logic [15:0] r_a_mag;
    logic [16:0] r_a_lo;
    logic [10:0] r_a_diff;
    logic [7:0]  r_a_frac;

    always_comb begin
        x_u   = i_x_value;
        mag   = x_u[15] ? (~x_u + 16'd1) : x_u;
        // tanh looks up sigmoid at twice the magnitude
        b_arg = (i_mode == MODE_TANH || i_mode == MODE_TANH_D) ? {mag, 1'b0} : {1'b0, mag};
        idx   = b_arg[16:8];
        lo    = idx[8] ? SIG_ROM[ROM_LAST] : SIG_ROM[idx[7:0]];
        hi    = (idx[8] || idx[7:0] == 8'hFF) ? SIG_ROM[ROM_LAST]
                                              : SIG_ROM[idx[7:0] + 8'd1];
        diff  = (hi >= lo) ? 11'(hi - lo) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_a_x    <= x_u;
            r_a_mag  <= mag;
            r_a_lo   <= lo;
            r_a_diff <= diff;
            r_a_frac <= b_arg[7:0];
        end
    end

    // ---------------- stage B: interpolation, leaky product ----------------
    logic [18:0] interp;
    logic [16:0] s_val;
    logic [28:0] leak;

    logic [15:0] r_b_x;
    logic [16:0] r_b_s;
    logic [28:0] r_b_leak;

    always_comb begin
        interp = 19'(r_a_diff) * 19'(r_a_frac) + 19'd128;
        s_val  = r_a_lo + 17'(interp[18:8]);
        leak   = 29'(r_a_mag) * 29'(i_alpha);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_b_x    <= r_a_x;
            r_b_s    <= s_val;
            r_b_leak <= leak;
        end
    end

    // ---------------- stage C: derivative multiply ----------------
    logic [16:0] t_val;
    logic [16:0] op_a;
    logic [16:0] op_b;
    logic [33:0] mul;

    logic [15:0] r_c_x;
    logic [16:0] r_c_s;
    logic [16:0] r_c_t;
    logic [32:0] r_c_prod;
    logic [28:0] r_c_leak;

    always_comb begin
        t_val = 17'({r_b_s, 1'b0} - 18'd65536);
        op_a  = (i_mode == MODE_TANH_D) ? t_val : r_b_s;
        op_b  = (i_mode == MODE_TANH_D) ? t_val : 17'(18'd65536 - 18'(r_b_s));
        mul   = 34'(op_a) * 34'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_c_x    <= r_b_x;
            r_c_s    <= r_b_s;
            r_c_t    <= t_val;
            r_c_prod <= mul[32:0];
            r_c_leak <= r_b_leak;
        end
    end

    // ---------------- stage D: round, select, saturate ----------------
    logic               x_pos;
    logic               x_neg;
    logic [17:0]        sig_rnd;
    logic [17:0]        tanh_rnd;
    logic [33:0]        sigd_rnd;
    logic [33:0]        tanhd_rnd;
    logic [28:0]        leak_rnd;
    logic signed [18:0] y_wide;
    logic [15:0]        y_sat;

    logic [15:0]        r_y;

    always_comb begin
        x_neg     = r_c_x[15];
        x_pos     = !r_c_x[15] && (r_c_x != 16'd0);
        sig_rnd   = x_neg ? (18'd65536 - 18'(r_c_s) + 18'd8) : (18'(r_c_s) + 18'd8);
        tanh_rnd  = 18'(r_c_t) + 18'd8;
        sigd_rnd  = 34'(r_c_prod) + 34'd524288;
        tanhd_rnd = 34'h1_0000_0000 - 34'(r_c_prod) + 34'd524288;
        leak_rnd  = r_c_leak + 29'd2048;

        case (i_mode)
            MODE_SIGMOID:   y_wide = 19'(sig_rnd[17:4]);
            MODE_SIGMOID_D: y_wide = 19'(sigd_rnd[33:20]);
            MODE_TANH:      y_wide = x_neg ? -19'(tanh_rnd[17:4]) : 19'(tanh_rnd[17:4]);
            MODE_TANH_D:    y_wide = 19'(tanhd_rnd[33:20]);
            MODE_RELU:      y_wide = x_pos ? 19'(r_c_x) : '0;
            MODE_RELU_D:    y_wide = x_pos ? 19'd4096 : '0;
            MODE_LEAKY:     y_wide = x_pos ? 19'(r_c_x) : -19'(leak_rnd[28:12]);
            MODE_LEAKY_D:   y_wide = x_pos ? 19'd4096 : 19'(i_alpha);
            default:        y_wide = '0;
        endcase

        if (y_wide > 19'sd32767) begin
            y_sat = 16'h7FFF;
        end else if (y_wide < -19'sd32768) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y_wide[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_y <= y_sat;
        end
    end

    assign o_y_value = r_y;

endmodule

>>> test/activation_function_unit_tb.sv
// Testbench for activation_function_unit: random and edge-value samples under every mode.
// Predicts each result from a locally built sigmoid table; needs afu_pkg and the DUT only.
module activation_function_unit_tb import afu_pkg::*;;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [2:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic signed [15:0] i_x_value   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [15:0] o_y_value;
    logic               i_out_stall = 1'b0;

    // sigmoid(k/16) in unsigned Q0.16
    int unsigned        sig_table [0:ROM_LAST];
    t_mode              cfg_mode  = MODE_SIGMOID;
    logic [12:0]        cfg_alpha = ALPHA_RESET;

    logic signed [15:0] samples_to_send [$];
    logic signed [15:0] y_predicted [$];
    int                 samples_queued   = 0;
    int                 samples_accepted = 0;
    int                 mismatch_count   = 0;
    bit                 x_accepted       = 1'b0;
    bit                 steady_phase     = 1'b0;
    int                 send_gap         = 0;
    int                 stall_left       = 0;

    activation_function_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_x_value  (i_x_value),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_y_value  (o_y_value),
        .i_out_stall(i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned sig_interp(input int unsigned b);
        int unsigned idx;
        int unsigned frac;
        int unsigned nxt;
        int unsigned lo;
        int unsigned hi;
        int unsigned diff;
        idx  = b >> 8;
        frac = b & 32'd255;
        if (idx > ROM_LAST) idx = ROM_LAST;
        nxt  = (idx < ROM_LAST) ? idx + 1 : ROM_LAST;
        lo   = sig_table[idx];
        hi   = sig_table[nxt];
        diff = (hi >= lo) ? hi - lo : 0;
        return lo + ((diff * frac + 32'd128) >> 8);
    endfunction

    function automatic logic signed [15:0] predict_y(input logic signed [15:0] x);
        int                xi;
        int unsigned       mag;
        int unsigned       s;
        int unsigned       t;
        int unsigned       q;
        longint unsigned   v;
        int                y;
        xi  = x;
        mag = (xi < 0) ? -xi : xi;
        y   = 0;
        case (cfg_mode)
            MODE_SIGMOID: begin
                s = sig_interp(mag);
                y = (xi >= 0) ? int'((s + 32'd8) >> 4) : int'((32'd65536 - s + 32'd8) >> 4);
            end
            MODE_SIGMOID_D: begin
                s = sig_interp(mag);
                v = s;
                v = v * longint'(32'd65536 - s);
                y = int'((v + (64'd1 << 19)) >> 20);
            end
            MODE_TANH: begin
                t = 2 * sig_interp(2 * mag) - 32'd65536;
                y = int'((t + 32'd8) >> 4);
                if (xi < 0) y = -y;
            end
            MODE_TANH_D: begin
                t = 2 * sig_interp(2 * mag) - 32'd65536;
                v = t;
                v = (64'd1 << 32) - v * v;
                y = int'((v + (64'd1 << 19)) >> 20);
            end
            MODE_RELU:   y = (xi > 0) ? xi : 0;
            MODE_RELU_D: y = (xi > 0) ? 4096 : 0;
            MODE_LEAKY: begin
                if (xi > 0) begin
                    y = xi;
                end else begin
                    q = (mag * cfg_alpha + 32'd2048) >> 12;
                    y = -int'(q);
                end
            end
            MODE_LEAKY_D: y = (xi > 0) ? 4096 : int'(cfg_alpha);
            default:      y = 0;
        endcase
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return 16'(y);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 9))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                3: return 16'sd1;
                4: return -16'sd1;
                5: return 16'sd4096;
                6: return -16'sd4096;
                7: return 16'(($urandom_range(0, 127) << 8));
                8: return 16'(($urandom_range(0, 127) << 7) + 1);
                default: return -16'(($urandom_range(1, 128) << 8));
            endcase
        end
        if (r < 50) return 16'(int'($urandom_range(0, 16383)) - 8192);
        return 16'($urandom());
    endfunction

    // input driver: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_in_valid || x_accepted) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   = send_gap - 1;
            end else if (samples_to_send.size() > 0) begin
                i_in_valid <= 1'b1;
                i_x_value  <= samples_to_send.pop_front();
                send_gap   = steady_phase ? 0 : pick_idle();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  = steady_phase ? 0 : pick_idle();
        end
    end

    // monitor: predict on every input beat, check every output beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            x_accepted = i_in_valid && !o_in_stall;
            if (x_accepted) begin
                y_predicted.push_back(predict_y(i_x_value));
                samples_accepted = samples_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (y_predicted.size() == 0) begin
                    $error("unexpected output beat: y_value actual %0d", o_y_value);
                    mismatch_count = mismatch_count + 1;
                end else if (o_y_value !== y_predicted[0]) begin
                    $error("y_value mismatch: expected %0d, actual %0d",
                           y_predicted[0], o_y_value);
                    mismatch_count = mismatch_count + 1;
                    void'(y_predicted.pop_front());
                end else begin
                    void'(y_predicted.pop_front());
                end
            end
        end else begin
            x_accepted = 1'b0;
        end
    end

    task automatic apb_write(input logic reg_sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_mode(input t_mode m);
        apb_write(REG_MODE, ($urandom() & ~32'h7) | 32'(m));
        cfg_mode = m;
    endtask

    task automatic write_alpha(input logic [12:0] a);
        apb_write(REG_ALPHA, ($urandom() & ~32'h1FFF) | 32'(a));
        cfg_alpha = a;
    endtask

    task automatic queue_sample(input logic signed [15:0] x);
        samples_to_send.push_back(x);
        samples_queued = samples_queued + 1;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_accepted != samples_queued || y_predicted.size() != 0);
    endtask

    initial begin
        longint unsigned e;
        longint unsigned d;
        logic [12:0]     alpha_pick [8];
        t_mode           m;

        e = 64'd1 << 32;
        for (int k = 0; k <= ROM_LAST; k++) begin
            d = (64'd1 << 32) + e;
            sig_table[k] = 32'(((64'd1 << 48) + (d >> 1)) / d);
            e = (e * ROM_STEP_C + (64'd1 << 31)) >> 32;
        end
        alpha_pick = '{13'd0, 13'd1, 13'd41, 13'd2048, 13'd4095, 13'd4096, 13'd4097, 13'd8191};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes under every mode; sigmoid and the first leaky run use reset values
        for (int k = 0; k < 8; k++) begin
            m = t_mode'(k);
            if (k != 0) write_mode(m);
            if (m == MODE_LEAKY_D) write_alpha(13'd8191);
            queue_sample(-16'sd32768);
            queue_sample(16'sd32767);
            queue_sample(16'sd0);
            wait_drained();
        end

        for (int p = 0; p < 24; p++) begin
            m = (p < 8) ? t_mode'(p) : t_mode'($urandom_range(0, 7));
            write_mode(m);
            write_alpha((p < 16) ? alpha_pick[p % 8] : 13'($urandom_range(0, 8191)));
            steady_phase = (p % 5 == 2);
            for (int n = 0; n < 25; n++) queue_sample(random_sample());
            // hold the sender until the pipeline has drained
            wait_drained();
        end

        steady_phase = 1'b0;
        repeat (2 * NUM_STAGES + 4) @(posedge i_clk);
        if (mismatch_count == 0 && y_predicted.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
